// ===== rtl/core/sfd_pkg.sv =====
`timescale 1ns / 1ps

package sfd_pkg;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_ESC  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        OP_LEN  = 2'd0,
        OP_DATA = 2'd1,
        OP_END  = 2'd2,
        OP_BAD  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_MAX_LENGTH     = 3'd0,
        CFG_END_CODE       = 3'd1,
        CFG_ESCAPE_CODE    = 3'd2,
        CFG_ESC_END_CODE   = 3'd3,
        CFG_ESC_ESC_CODE   = 3'd4,
        CFG_START_CODE     = 3'd5
    } cfg_idx_t;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_EMPTY     = 2'd1;
    localparam logic [1:0] ERR_CHECKSUM  = 2'd2;
    localparam logic [1:0] ERR_MALFORMED = 2'd3;

    localparam logic [7:0] SUM_MASK = 8'h7f;

    localparam logic [7:0] RST_MAX_LENGTH   = 8'd255;
    localparam logic [7:0] RST_END_CODE     = 8'd192;
    localparam logic [7:0] RST_ESCAPE_CODE  = 8'd219;
    localparam logic [7:0] RST_ESC_END_CODE = 8'd220;
    localparam logic [7:0] RST_ESC_ESC_CODE = 8'd221;
    localparam logic [7:0] RST_START_CODE   = 8'd193;

    typedef struct packed {
        logic [7:0] max_length;
        logic [7:0] end_code;
        logic [7:0] escape_code;
        logic [7:0] escaped_end_code;
        logic [7:0] escaped_escape_code;
        logic [7:0] start_code;
    } cfg_t;

    // one classified item passed from front to back
    typedef struct packed {
        op_t        op;
        logic [7:0] value;
    } op_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== rtl/core/slip_frame_decoder_core.sv =====
`timescale 1ns / 1ps

// channel | signals                               | role
// --------+---------------------------------------+-------------------------------
// in      | in_valid, in_ready, rx_byte           | raw line bytes, one per item
// out     | out_valid, out_ready, kind,           | payload byte or frame verdict
//         | payload_byte, frame_count, error_code |
// cfg     | cfg_valid, cfg_ready, cfg_index,      | code and limit registers,
//         | cfg_data                              | always ready
//
// One byte per cycle sustained while out_ready stays high; results go through
// front classify -> two-entry queue -> registered output stage.
// The front keeps the framing phase, the back keeps length, count, sum and
// last decoded byte and builds the verdict at the end code or a bad escape.
// At full rate the queue holds one item, so during an output stall it takes
// one more item (two when it starts empty) before in_ready drops; in_ready
// comes back in the cycle after out_ready does.
// Reset: hunting for start code, registers at their default codes.

module slip_frame_decoder_core
    import sfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] payload_byte,
    output logic [7:0] frame_count,
    output logic [1:0] error_code,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t      cfg_reg;
    q_status_t q_status;
    logic      push;
    op_item_t  push_item;
    logic      pop;
    op_item_t  head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_length          <= RST_MAX_LENGTH;
            cfg_reg.end_code            <= RST_END_CODE;
            cfg_reg.escape_code         <= RST_ESCAPE_CODE;
            cfg_reg.escaped_end_code    <= RST_ESC_END_CODE;
            cfg_reg.escaped_escape_code <= RST_ESC_ESC_CODE;
            cfg_reg.start_code          <= RST_START_CODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_LENGTH:   cfg_reg.max_length          <= cfg_data;
                CFG_END_CODE:     cfg_reg.end_code            <= cfg_data;
                CFG_ESCAPE_CODE:  cfg_reg.escape_code         <= cfg_data;
                CFG_ESC_END_CODE: cfg_reg.escaped_end_code    <= cfg_data;
                CFG_ESC_ESC_CODE: cfg_reg.escaped_escape_code <= cfg_data;
                CFG_START_CODE:   cfg_reg.start_code          <= cfg_data;
                default:          cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    sfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    sfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    sfd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_status     (q_status),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .payload_byte (payload_byte),
        .frame_count  (frame_count),
        .error_code   (error_code)
    );

endmodule

// ===== rtl/core/sfd_front.sv =====
`timescale 1ns / 1ps

module sfd_front
    import sfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [7:0] rx_byte,
    input  q_status_t q_status,
    output logic      push,
    output op_item_t  push_item
);

    phase_t phase_reg;
    phase_t phase_next;
    logic   take;

    assign in_ready = !q_status.full;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == cfg.start_code)
                    phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                // end wins over escape when both codes match
                if (rx_byte == cfg.end_code)
                    phase_next = PH_HUNT;
                else if (rx_byte == cfg.escape_code)
                    phase_next = PH_ESC;
            end
            PH_ESC:
            begin
                if (rx_byte == cfg.escaped_escape_code || rx_byte == cfg.escaped_end_code)
                    phase_next = PH_DATA;
                else
                    phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_comb
    begin
        push            = 1'b0;
        push_item.op    = OP_DATA;
        push_item.value = rx_byte;
        case (phase_reg)
            PH_HUNT:
            begin
                push = 1'b0;
            end
            PH_LEN:
            begin
                push         = take;
                push_item.op = OP_LEN;
            end
            PH_DATA:
            begin
                if (rx_byte == cfg.end_code)
                begin
                    push         = take;
                    push_item.op = OP_END;
                end
                else if (rx_byte != cfg.escape_code)
                begin
                    push = take;
                end
            end
            PH_ESC:
            begin
                push = take;
                if (rx_byte == cfg.escaped_escape_code)
                    push_item.value = cfg.escape_code;
                else if (rx_byte == cfg.escaped_end_code)
                    push_item.value = cfg.end_code;
                else
                    push_item.op = OP_BAD;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/sfd_queue.sv =====
`timescale 1ns / 1ps

module sfd_queue
    import sfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  op_item_t  push_item,
    input  logic      pop,
    output op_item_t  head,
    output q_status_t status
);

    op_item_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/core/sfd_back.sv =====
`timescale 1ns / 1ps

module sfd_back
    import sfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  q_status_t  q_status,
    input  op_item_t   head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] payload_byte,
    output logic [7:0] frame_count,
    output logic [1:0] error_code
);

    logic [7:0] declared_length_reg;
    logic [7:0] declared_length_next;
    logic [7:0] stored_count_reg;
    logic [7:0] stored_count_next;
    logic [7:0] running_sum_reg;
    logic [7:0] running_sum_next;
    logic [7:0] previous_byte_reg;
    logic [7:0] previous_byte_next;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;
    logic [7:0] payload_reg;
    logic [7:0] payload_next;
    logic [7:0] count_out_reg;
    logic [7:0] count_out_next;
    logic [1:0] error_reg;
    logic [1:0] error_next;

    logic       result;
    logic       room;

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = payload_reg;
    assign frame_count  = count_out_reg;
    assign error_code   = error_reg;

    assign pop = !q_status.empty && (!out_valid_reg || out_ready);

    assign room = (stored_count_reg < declared_length_reg)
               && (stored_count_reg < cfg.max_length);

    always_comb
    begin
        declared_length_next = declared_length_reg;
        stored_count_next    = stored_count_reg;
        running_sum_next     = running_sum_reg;
        previous_byte_next   = previous_byte_reg;
        result               = 1'b0;
        kind_next            = KIND_PAYLOAD;
        payload_next         = 8'd0;
        count_out_next       = stored_count_reg;
        error_next           = ERR_NONE;
        case (head.op)
            OP_LEN:
            begin
                declared_length_next = head.value;
                stored_count_next    = 8'd0;
                running_sum_next     = 8'd0;
                previous_byte_next   = 8'd0;
            end
            OP_DATA:
            begin
                previous_byte_next = head.value;
                if (room)
                begin
                    result            = 1'b1;
                    stored_count_next = stored_count_reg + 8'd1;
                    running_sum_next  = running_sum_reg + head.value;
                    payload_next      = head.value;
                    count_out_next    = stored_count_reg + 8'd1;
                end
            end
            OP_END:
            begin
                result = 1'b1;
                if (stored_count_reg == 8'd0)
                begin
                    kind_next  = KIND_REJECT;
                    error_next = ERR_EMPTY;
                end
                else if (previous_byte_reg == (running_sum_reg & SUM_MASK))
                begin
                    kind_next = KIND_ACCEPT;
                end
                else
                begin
                    kind_next  = KIND_REJECT;
                    error_next = ERR_CHECKSUM;
                end
            end
            OP_BAD:
            begin
                result     = 1'b1;
                kind_next  = KIND_REJECT;
                error_next = ERR_MALFORMED;
            end
            default:
            begin
                result = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = result;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            declared_length_reg <= 8'd0;
            stored_count_reg    <= 8'd0;
            running_sum_reg     <= 8'd0;
            previous_byte_reg   <= 8'd0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                declared_length_reg <= declared_length_next;
                stored_count_reg    <= stored_count_next;
                running_sum_reg     <= running_sum_next;
                previous_byte_reg   <= previous_byte_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && result)
        begin
            kind_reg      <= kind_next;
            payload_reg   <= payload_next;
            count_out_reg <= count_out_next;
            error_reg     <= error_next;
        end
    end

endmodule
